@@ rtl/core/waveform_envelope_crc_check_core_assert.svh @@
// Assertion macros shared by the envelope and CRC check checker.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef WAVEFORM_ENVELOPE_CRC_CHECK_CORE_ASSERT_SVH
`define WAVEFORM_ENVELOPE_CRC_CHECK_CORE_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define WECC_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// The antecedent implies the consequent at the same edge.
`define WECC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The antecedent implies the consequent at the next edge.
`define WECC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/wecc_pkg.sv @@
// Package for the waveform envelope and CRC check core.
// Holds widths, CRC constants, register indexes, item types and the CRC byte step.
`default_nettype none

package wecc_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int COUNT_W      = 16;
  localparam int ACC_W        = 17;
  localparam int COLUMN_W     = 8;
  localparam int CRC_W        = 32;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_INDEX_W  = 1;
  localparam int FIFO_ENTRIES = 4;

  localparam logic [CRC_W-1:0]    CRC_POLY          = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0]    CRC_ONES          = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0]  CAPTURE_LEN_RESET = 16'd4096;
  localparam logic [SAMPLE_W-1:0] SAMPLE_ONES       = 16'hFFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CAPTURE_LEN  = 1'b0,
    REG_EXPECTED_CRC = 1'b1
  } cfg_reg_t;

  // A classified sample as it travels from the front end to the back end.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [COLUMN_W-1:0] column;
    logic                closes;
    logic                last;
  } task_t;

  // One reported column.
  typedef struct packed {
    logic [COLUMN_W-1:0] column_index;
    logic [SAMPLE_W-1:0] column_low;
    logic [SAMPLE_W-1:0] column_high;
    logic                final_column;
    logic [SAMPLE_W-1:0] overall_min;
    logic [SAMPLE_W-1:0] overall_max;
    logic                crc_match;
  } result_t;

  // Reflected CRC-32 over one byte, one bit per step.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/waveform_envelope_crc_check_core.sv @@
// Waveform envelope decimator with CRC-32 check, top level.
// Depends on wecc_pkg, wecc_front, wecc_fifo and wecc_back.
//
// Usage: samples enter through a queue-style port (push, full); an item is
// taken when push is high and full is low. Results leave through a second
// queue-style port (empty, pop); the oldest result sits on the result ports
// while empty is low and is taken when pop is high.
// Each sample folds into the current column; a result appears when a column
// closes, and the last sample of a capture gives the last column together
// with the capture minimum, maximum and the CRC-32 compare.
// A closing sample is written into the task queue, and its result is
// registered in the result queue before it reaches the ports.
// Throughput: one sample per cycle while full is low, set by the position
// and column update in the front end and the 16-bit CRC step in the back end.
// A four-entry task queue separates front and back end; a four-entry result
// queue holds finished results while the receiver does not pop. When it
// fills, the back end stalls, then the task queue fills and full rises.
// Reset (rst, synchronous) empties both queues, clears the capture state and
// loads the capture length with 4096 and expected_crc with 0. Configuration
// is written through cfg_write, cfg_index and cfg_data.
`default_nettype none

module waveform_envelope_crc_check_core
  import wecc_pkg::*;
#(
  parameter int COLUMNS = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [SAMPLE_W-1:0]    sample,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [COLUMN_W-1:0]         column_index,
  output logic [SAMPLE_W-1:0]         column_low,
  output logic [SAMPLE_W-1:0]         column_high,
  output logic                        final_column,
  output logic [SAMPLE_W-1:0]         overall_min,
  output logic [SAMPLE_W-1:0]         overall_max,
  output logic                        crc_match,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [COUNT_W-1:0] capture_len;
  logic [CRC_W-1:0]   expected_crc;

  task_t   front_item;
  task_t   back_item;
  result_t back_result;
  result_t out_result;

  logic accept;
  logic task_empty;
  logic task_take;
  logic result_full;
  logic result_push;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_len  <= CAPTURE_LEN_RESET;
      expected_crc <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_CAPTURE_LEN) begin
        capture_len <= cfg_data[COUNT_W-1:0];
      end else if (cfg_index == REG_EXPECTED_CRC) begin
        expected_crc <= cfg_data[CRC_W-1:0];
      end
    end
  end

  assign accept = push && !full;

  // Front end: position and column tracking.
  wecc_front #(
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .sample      (sample),
    .capture_len (capture_len),
    .task_item   (front_item)
  );

  // Task queue between front and back end.
  wecc_fifo #(
    .WIDTH ($bits(task_t)),
    .DEPTH (FIFO_ENTRIES)
  ) u_task_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata (front_item),
    .pop   (task_take),
    .empty (task_empty),
    .rdata (back_item)
  );

  // Back end: extremes, CRC and result forming.
  wecc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .task_valid   (!task_empty),
    .task_item    (back_item),
    .task_take    (task_take),
    .result_full  (result_full),
    .expected_crc (expected_crc),
    .result_push  (result_push),
    .result_item  (back_result)
  );

  // Result queue toward the receiver.
  wecc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (FIFO_ENTRIES)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (result_push),
    .full  (result_full),
    .wdata (back_result),
    .pop   (pop),
    .empty (empty),
    .rdata (out_result)
  );

  assign column_index = out_result.column_index;
  assign column_low   = out_result.column_low;
  assign column_high  = out_result.column_high;
  assign final_column = out_result.final_column;
  assign overall_min  = out_result.overall_min;
  assign overall_max  = out_result.overall_max;
  assign crc_match    = out_result.crc_match;

endmodule

`default_nettype wire

@@ rtl/core/wecc_fifo.sv @@
// Small first-word-fall-through queue with full and empty flags.
// Generic storage; used between front and back end and on the result side.
`default_nettype none

module wecc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      rdata
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  mem [DEPTH];
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wecc_front.sv @@
// Front end: accepts samples, tracks position and column, classifies each item.
// Depends on wecc_pkg; feeds the task queue.
`default_nettype none

module wecc_front
  import wecc_pkg::*;
#(
  parameter int COLUMNS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic [COUNT_W-1:0] capture_len,
  output task_t                   task_item
);

  localparam logic [ACC_W-1:0]   COL_STEP = ACC_W'(COLUMNS);
  localparam logic [COUNT_W-1:0] COL_MIN  = COUNT_W'(COLUMNS);

  logic [COUNT_W-1:0]  position;
  logic [ACC_W-1:0]    accumulator;
  logic [COLUMN_W-1:0] column;

  logic [COUNT_W-1:0] n_eff;
  logic [ACC_W-1:0]   acc_sum;
  logic               last;
  logic               closes;

  // Effective count is never below the column count.
  assign n_eff   = (capture_len < COL_MIN) ? COL_MIN : capture_len;
  assign last    = (position >= (n_eff - 1'b1));
  assign acc_sum = accumulator + COL_STEP;
  assign closes  = last || (acc_sum >= {1'b0, n_eff});

  assign task_item.sample = sample;
  assign task_item.column = column;
  assign task_item.closes = closes;
  assign task_item.last   = last;

  // Position, accumulator and column advance on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      accumulator <= '0;
      column      <= '0;
    end else if (accept) begin
      if (last) begin
        position    <= '0;
        accumulator <= '0;
        column      <= '0;
      end else if (closes) begin
        position    <= position + 1'b1;
        accumulator <= acc_sum - {1'b0, n_eff};
        column      <= column + 1'b1;
      end else begin
        position    <= position + 1'b1;
        accumulator <= acc_sum;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wecc_back.sv @@
// Back end: folds samples into column and capture extremes, runs the CRC-32,
// and forms result items. Depends on wecc_pkg; reads the task queue.
`default_nettype none

module wecc_back
  import wecc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             task_valid,
  input  wire task_t            task_item,
  output logic                  task_take,
  input  wire logic             result_full,
  input  wire logic [CRC_W-1:0] expected_crc,
  output logic                  result_push,
  output result_t               result_item
);

  logic [SAMPLE_W-1:0] col_low;
  logic [SAMPLE_W-1:0] col_high;
  logic [SAMPLE_W-1:0] cap_min;
  logic [SAMPLE_W-1:0] cap_max;
  logic [CRC_W-1:0]    crc;

  logic [SAMPLE_W-1:0] col_low_next;
  logic [SAMPLE_W-1:0] col_high_next;
  logic [SAMPLE_W-1:0] cap_min_next;
  logic [SAMPLE_W-1:0] cap_max_next;
  logic [CRC_W-1:0]    crc_next;
  logic                emits;

  // Running extremes and the two-byte CRC step, low byte first.
  always_comb begin
    col_low_next  = (task_item.sample < col_low)  ? task_item.sample : col_low;
    col_high_next = (task_item.sample > col_high) ? task_item.sample : col_high;
    cap_min_next  = (task_item.sample < cap_min)  ? task_item.sample : cap_min;
    cap_max_next  = (task_item.sample > cap_max)  ? task_item.sample : cap_max;
    crc_next      = crc_byte(crc_byte(crc, task_item.sample[7:0]), task_item.sample[15:8]);
  end

  // An item that closes a column needs room on the result side.
  assign emits       = task_item.closes;
  assign task_take   = task_valid && (!emits || !result_full);
  assign result_push = task_take && emits;

  // Result fields; capture totals only travel with the last column.
  always_comb begin
    result_item.column_index = task_item.column;
    result_item.column_low   = col_low_next;
    result_item.column_high  = col_high_next;
    result_item.final_column = task_item.last;
    result_item.overall_min  = task_item.last ? cap_min_next : '0;
    result_item.overall_max  = task_item.last ? cap_max_next : '0;
    result_item.crc_match    = task_item.last && ((crc_next ^ CRC_ONES) == expected_crc);
  end

  // Capture state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_low  <= SAMPLE_ONES;
      col_high <= '0;
      cap_min  <= SAMPLE_ONES;
      cap_max  <= '0;
      crc      <= CRC_ONES;
    end else if (task_take) begin
      if (task_item.last) begin
        col_low  <= SAMPLE_ONES;
        col_high <= '0;
        cap_min  <= SAMPLE_ONES;
        cap_max  <= '0;
        crc      <= CRC_ONES;
      end else begin
        col_low  <= task_item.closes ? SAMPLE_ONES : col_low_next;
        col_high <= task_item.closes ? '0 : col_high_next;
        cap_min  <= cap_min_next;
        cap_max  <= cap_max_next;
        crc      <= crc_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wecc_checker.sv @@
// Port-level checker for the envelope and CRC check core, with its bind.
// Depends on wecc_pkg and the assertion macro header.
`default_nettype none

`include "waveform_envelope_crc_check_core_assert.svh"

module wecc_checker
  import wecc_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                empty,
  input wire logic                pop,
  input wire logic [SAMPLE_W-1:0] column_low,
  input wire logic [SAMPLE_W-1:0] column_high,
  input wire logic                final_column,
  input wire logic [SAMPLE_W-1:0] overall_min,
  input wire logic [SAMPLE_W-1:0] overall_max,
  input wire logic                crc_match
);

  // Every reported column holds at least one sample.
  `WECC_ASSERT_IMPLY(col_order_a, clk, rst, !empty, column_low <= column_high)

  // Capture totals are zero except on the last column.
  `WECC_ASSERT_IMPLY(totals_zero_a, clk, rst, !empty && !final_column, overall_min == '0 && overall_max == '0 && !crc_match)

  // The last column lies inside the capture's range.
  `WECC_ASSERT_IMPLY(final_range_a, clk, rst, !empty && final_column, column_low >= overall_min && column_high <= overall_max)

  // Reset leaves no result waiting.
  `WECC_ASSERT_NEXT(reset_empty_a, clk, 1'b0, rst, empty)

  // A waiting result stays until it is popped.
  `WECC_ASSERT_NEXT(hold_a, clk, rst, !empty && !pop, !empty)

endmodule

bind waveform_envelope_crc_check_core wecc_checker u_wecc_checker (
  .clk          (clk),
  .rst          (rst),
  .empty        (empty),
  .pop          (pop),
  .column_low   (column_low),
  .column_high  (column_high),
  .final_column (final_column),
  .overall_min  (overall_min),
  .overall_max  (overall_max),
  .crc_match    (crc_match)
);

`default_nettype wire
